### hw/rtl/iw3d_pkg.sv
// Shared types, constants and the sinc table function for the 3D interpolation weight unit.
`default_nettype none

package iw3d_pkg;

    // Widths of the fields of one item.
    localparam int COORD_W  = 32;
    localparam int BASE_W   = 16;
    localparam int WEIGHT_W = 17;
    localparam int FRAC_W   = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_KERNEL_MODE = 1'b0;

    // Fixed-point constants.
    localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [63:0]         PI_Q28   = 64'd843314857;
    localparam logic [63:0]         ONE_Q28  = 64'd268435456;
    localparam int                  SINC_TERMS = 12;

    // Divisors (2k)(2k+1) of the sin(x)/x series, for k = 1 .. SINC_TERMS.
    localparam logic [63:0] SINC_DIV [SINC_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef enum logic [1:0] {
        KERNEL_NEAREST  = 2'd0,
        KERNEL_LINEAR   = 2'd1,
        KERNEL_SINC     = 2'd2,
        KERNEL_RESERVED = 2'd3
    } t_kernel;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_coord_item;

    typedef struct packed {
        logic signed [BASE_W-1:0] base_x;
        logic signed [BASE_W-1:0] base_y;
        logic signed [BASE_W-1:0] base_z;
        logic [WEIGHT_W-1:0]      weight_000;
        logic [WEIGHT_W-1:0]      weight_001;
        logic [WEIGHT_W-1:0]      weight_010;
        logic [WEIGHT_W-1:0]      weight_011;
        logic [WEIGHT_W-1:0]      weight_100;
        logic [WEIGHT_W-1:0]      weight_101;
        logic [WEIGHT_W-1:0]      weight_110;
        logic [WEIGHT_W-1:0]      weight_111;
    } t_weight_item;

    // Normalized sinc of u / 2^16 in Q16, evaluated while the table is built.
    // A Q28 Taylor series of sin(x)/x with each term truncated, clamped to [0, 1],
    // then rounded half up to Q16.
    function automatic logic [WEIGHT_W-1:0] sinc_q16(input logic [WEIGHT_W-1:0] u);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = (PI_Q28 * 64'(u)) >> 16;
        x2   = (x * x) >> 28;
        term = ONE_Q28;
        sum  = $signed(ONE_Q28);
        for (int k = 1; k <= SINC_TERMS; k++) begin
            term = ((term * x2) >> 28) / SINC_DIV[k-1];
            if ((k & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q28)) begin
            sum = $signed(ONE_Q28);
        end
        r = ($unsigned(sum) + 64'd2048) >> 12;
        if (r > 64'(ONE_Q16)) begin
            r = 64'(ONE_Q16);
        end
        return r[WEIGHT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/iw3d_axis.sv
// One axis: splits a coordinate into floor and fraction and registers the low and high factors.
`default_nettype none

module iw3d_axis #(
    parameter int SINC_TABLE_BITS = 10,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [iw3d_pkg::COORD_W-1:0]    i_coord,
    input  wire iw3d_pkg::t_kernel                      i_mode,
    output logic signed [iw3d_pkg::BASE_W-1:0]          o_base,
    output logic [iw3d_pkg::WEIGHT_W-1:0]               o_lo,
    output logic [iw3d_pkg::WEIGHT_W-1:0]               o_hi
);

    localparam int TBL_DEPTH = 2 ** SINC_TABLE_BITS;
    localparam int TBL_SHIFT = iw3d_pkg::FRAC_W - SINC_TABLE_BITS;
    localparam int EXT_W     = iw3d_pkg::COORD_W + iw3d_pkg::BASE_W;

    typedef logic [iw3d_pkg::WEIGHT_W-1:0] t_sinc_rom [TBL_DEPTH];

    // Low factor table: sinc(t) for t = i / 2^SINC_TABLE_BITS.
    function automatic t_sinc_rom build_lo_rom();
        t_sinc_rom rom;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            rom[i] = iw3d_pkg::sinc_q16(17'(i) << TBL_SHIFT);
        end
        return rom;
    endfunction

    // High factor table: sinc(1 - t).
    function automatic t_sinc_rom build_hi_rom();
        t_sinc_rom rom;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            rom[i] = iw3d_pkg::sinc_q16(iw3d_pkg::ONE_Q16 - (17'(i) << TBL_SHIFT));
        end
        return rom;
    endfunction

    localparam t_sinc_rom LO_ROM = build_lo_rom();
    localparam t_sinc_rom HI_ROM = build_hi_rom();

    logic signed [EXT_W-1:0]             coord_ext;
    logic [iw3d_pkg::FRAC_W-1:0]         frac16;
    logic [SINC_TABLE_BITS-1:0]          tbl_idx;
    logic [iw3d_pkg::WEIGHT_W-1:0]       n_lo;
    logic [iw3d_pkg::WEIGHT_W-1:0]       n_hi;
    logic signed [iw3d_pkg::BASE_W-1:0]  r_base;
    logic [iw3d_pkg::WEIGHT_W-1:0]       r_lo;
    logic [iw3d_pkg::WEIGHT_W-1:0]       r_hi;
    logic [iw3d_pkg::WEIGHT_W-1:0]       r_sinc_lo;
    logic [iw3d_pkg::WEIGHT_W-1:0]       r_sinc_hi;
    logic                                r_is_sinc;

    // The floor is an arithmetic shift; the sign extension covers wide fractions.
    assign coord_ext = EXT_W'(i_coord);

    generate
        if (FRACTION_BITS >= iw3d_pkg::FRAC_W) begin : g_frac_trunc
            assign frac16 = i_coord[FRACTION_BITS-1 -: iw3d_pkg::FRAC_W];
        end else begin : g_frac_pad
            assign frac16 = {i_coord[FRACTION_BITS-1:0],
                             {(iw3d_pkg::FRAC_W - FRACTION_BITS){1'b0}}};
        end
    endgenerate

    assign tbl_idx = frac16[iw3d_pkg::FRAC_W-1 -: SINC_TABLE_BITS];

    // Factors of the kernels that need no table; the sinc tables are read
    // straight into their own registers below.
    always_comb begin
        unique case (i_mode)
            iw3d_pkg::KERNEL_NEAREST: begin
                // Rounds to the high corner at exactly one half.
                n_hi = frac16[iw3d_pkg::FRAC_W-1] ? iw3d_pkg::ONE_Q16 : '0;
                n_lo = iw3d_pkg::ONE_Q16 - n_hi;
            end
            iw3d_pkg::KERNEL_LINEAR: begin
                n_hi = iw3d_pkg::WEIGHT_W'(frac16);
                n_lo = iw3d_pkg::ONE_Q16 - iw3d_pkg::WEIGHT_W'(frac16);
            end
            iw3d_pkg::KERNEL_SINC: begin
                n_lo = '0;
                n_hi = '0;
            end
            iw3d_pkg::KERNEL_RESERVED: begin
                n_lo = '0;
                n_hi = '0;
            end
            default: begin
                n_lo = '0;
                n_hi = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base    <= coord_ext[FRACTION_BITS +: iw3d_pkg::BASE_W];
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_sinc_lo <= LO_ROM[tbl_idx];
            r_sinc_hi <= HI_ROM[tbl_idx];
            r_is_sinc <= (i_mode == iw3d_pkg::KERNEL_SINC);
        end
    end

    // The kernel choice, registered with the item, picks the table data or the
    // other factors after the register.
    assign o_base = r_base;
    assign o_lo   = r_is_sinc ? r_sinc_lo : r_lo;
    assign o_hi   = r_is_sinc ? r_sinc_hi : r_hi;

endmodule

`default_nettype wire

### hw/rtl/interpolation_weight_3d_unit.sv
// Top level of the 3D interpolation weight unit: pipeline, handshakes and configuration register.
`default_nettype none

// The unit takes one sample point per item, in signed fixed point with FRACTION_BITS
// fraction bits per axis, and returns the floor grid corner together with the eight
// corner weights in unsigned Q1.16. It accepts one item every clock cycle while o_stall
// is low, and each item passes three register stages: the axis factor registers, the
// partial weight registers and the output register. The first stage splits the three
// coordinates and forms the per-axis low and high factors (nearest, linear or a
// registered sinc table read), the second multiplies the y and z factors into four
// rounded partial weights, and the third multiplies those by the x factors into the
// eight rounded corner weights, which sit in the output register until
// taken. These three stages set the latency. A stall on the output is absorbed stage by
// stage, so the input keeps accepting items while any stage is empty and nothing is
// lost or repeated. The kernel is chosen by the kernel_mode register at byte address 0
// (0 nearest, 1 linear, 2 sinc, 3 all weights zero; linear after reset); write it only
// while no item is in flight. The sinc kernel reads two constant tables of
// 2^SINC_TABLE_BITS entries per axis, indexed by the top fraction bits. There is no
// clearing pass after reset; the unit is ready to accept items right after reset.

module interpolation_weight_3d_unit #(
    parameter int SINC_TABLE_BITS = 10,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    // Sample point items.
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire iw3d_pkg::t_coord_item                 i_data,

    // Weight items.
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output iw3d_pkg::t_weight_item                     o_data,

    // Configuration port.
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [iw3d_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [iw3d_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [iw3d_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                       pready
);

    localparam int WW = iw3d_pkg::WEIGHT_W;

    // Rounded Q16 product, half up. The result never exceeds one in Q1.16.
    function automatic logic [WW-1:0] mul_round(input logic [WW-1:0] a,
                                                input logic [WW-1:0] b);
        logic [2*WW-1:0] p;
        p = (2*WW)'(a) * (2*WW)'(b) + (2*WW)'(32768);
        return p[16 +: WW];
    endfunction

    // ------------------------------------------------------------------
    // Configuration register. Writes complete in the access phase; the
    // port never waits.
    // ------------------------------------------------------------------
    iw3d_pkg::t_kernel r_kernel;
    logic              cfg_write;
    logic              cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[iw3d_pkg::APB_ADDR_W-1] == iw3d_pkg::REG_KERNEL_MODE);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= iw3d_pkg::KERNEL_LINEAR;
        end else if (cfg_write && cfg_hit) begin
            r_kernel <= iw3d_pkg::t_kernel'(pwdata[1:0]);
        end
    end

    assign prdata = cfg_hit ? iw3d_pkg::APB_DATA_W'(r_kernel) : '0;

    // ------------------------------------------------------------------
    // Pipeline control. Each stage loads when it is empty or when the
    // stage after it moves, so bubbles are squeezed out under a stall.
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: floor and per-axis factors, one unit per axis.
    // ------------------------------------------------------------------
    logic signed [iw3d_pkg::BASE_W-1:0] s1_base_x;
    logic signed [iw3d_pkg::BASE_W-1:0] s1_base_y;
    logic signed [iw3d_pkg::BASE_W-1:0] s1_base_z;
    logic [WW-1:0]                      s1_fx [2];
    logic [WW-1:0]                      s1_fy [2];
    logic [WW-1:0]                      s1_fz [2];

    iw3d_axis #(
        .SINC_TABLE_BITS (SINC_TABLE_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_coord (i_data.coord_x),
        .i_mode  (r_kernel),
        .o_base  (s1_base_x),
        .o_lo    (s1_fx[0]),
        .o_hi    (s1_fx[1])
    );

    iw3d_axis #(
        .SINC_TABLE_BITS (SINC_TABLE_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_coord (i_data.coord_y),
        .i_mode  (r_kernel),
        .o_base  (s1_base_y),
        .o_lo    (s1_fy[0]),
        .o_hi    (s1_fy[1])
    );

    iw3d_axis #(
        .SINC_TABLE_BITS (SINC_TABLE_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_axis_z (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_coord (i_data.coord_z),
        .i_mode  (r_kernel),
        .o_base  (s1_base_z),
        .o_lo    (s1_fz[0]),
        .o_hi    (s1_fz[1])
    );

    // ------------------------------------------------------------------
    // Stage 2: the four y-z partial weights, indexed {b, c}.
    // ------------------------------------------------------------------
    logic signed [iw3d_pkg::BASE_W-1:0] r_base_x2;
    logic signed [iw3d_pkg::BASE_W-1:0] r_base_y2;
    logic signed [iw3d_pkg::BASE_W-1:0] r_base_z2;
    logic [WW-1:0]                      r_fx2 [2];
    logic [WW-1:0]                      r_yz  [4];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_base_x2 <= s1_base_x;
            r_base_y2 <= s1_base_y;
            r_base_z2 <= s1_base_z;
            r_fx2[0]  <= s1_fx[0];
            r_fx2[1]  <= s1_fx[1];
            for (int b = 0; b < 2; b++) begin
                for (int c = 0; c < 2; c++) begin
                    r_yz[b*2 + c] <= mul_round(s1_fy[b], s1_fz[c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the eight corner weights, indexed {a, b, c}, into the
    // output register.
    // ------------------------------------------------------------------
    logic [WW-1:0]          n_w [8];
    iw3d_pkg::t_weight_item n_out;
    iw3d_pkg::t_weight_item r_out;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int bc = 0; bc < 4; bc++) begin
                n_w[a*4 + bc] = mul_round(r_fx2[a], r_yz[bc]);
            end
        end
    end

    always_comb begin
        n_out.base_x     = r_base_x2;
        n_out.base_y     = r_base_y2;
        n_out.base_z     = r_base_z2;
        n_out.weight_000 = n_w[0];
        n_out.weight_001 = n_w[1];
        n_out.weight_010 = n_w[2];
        n_out.weight_011 = n_w[3];
        n_out.weight_100 = n_w[4];
        n_out.weight_101 = n_w[5];
        n_out.weight_110 = n_w[6];
        n_out.weight_111 = n_w[7];
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

### hw/rtl/iw3d_checker.sv
// Port-level checker for the 3D interpolation weight unit and its bind to the top level.
`default_nettype none

module iw3d_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic                                  o_stall,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_stall,
    input  wire iw3d_pkg::t_weight_item                o_data,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [iw3d_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [iw3d_pkg::APB_DATA_W-1:0]       pwdata,
    input  wire logic                                  pready
);

    localparam logic [2:0] MAX_IN_FLIGHT = 3'd3;

    logic              in_acc;
    logic              out_acc;
    logic [2:0]        r_count;
    iw3d_pkg::t_kernel r_mode;
    logic [16:0]       w [8];

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign w[0] = o_data.weight_000;
    assign w[1] = o_data.weight_001;
    assign w[2] = o_data.weight_010;
    assign w[3] = o_data.weight_011;
    assign w[4] = o_data.weight_100;
    assign w[5] = o_data.weight_101;
    assign w[6] = o_data.weight_110;
    assign w[7] = o_data.weight_111;

    // Items inside the unit, counted from the ports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 3'(in_acc) - 3'(out_acc);
        end
    end

    // Mirror of the kernel register, taken from completed writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= iw3d_pkg::KERNEL_LINEAR;
        end else if (psel && penable && pwrite && pready &&
                     paddr[iw3d_pkg::APB_ADDR_W-1] == iw3d_pkg::REG_KERNEL_MODE) begin
            r_mode <= iw3d_pkg::t_kernel'(pwdata[1:0]);
        end
    end

    // A result waiting under a stall is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("weight item changed while stalled");

    // The pipeline never holds more than its three stages, and shows no item it was not given.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= MAX_IN_FLIGHT) && (!o_valid || r_count != 3'd0))
        else $error("item count inside the unit out of bounds");

    // The reserved kernel gives all-zero weights.
    a_reserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_mode == iw3d_pkg::KERNEL_RESERVED |->
            w[0] == '0 && w[1] == '0 && w[2] == '0 && w[3] == '0 &&
            w[4] == '0 && w[5] == '0 && w[6] == '0 && w[7] == '0)
        else $error("reserved kernel gave a nonzero weight");

    // The nearest kernel puts full weight on exactly one corner.
    a_nearest_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_mode == iw3d_pkg::KERNEL_NEAREST |->
            $onehot({w[0] == 17'h10000, w[1] == 17'h10000, w[2] == 17'h10000,
                     w[3] == 17'h10000, w[4] == 17'h10000, w[5] == 17'h10000,
                     w[6] == 17'h10000, w[7] == 17'h10000}) &&
            $countones({w[0] == '0, w[1] == '0, w[2] == '0, w[3] == '0,
                        w[4] == '0, w[5] == '0, w[6] == '0, w[7] == '0}) == 7)
        else $error("nearest kernel did not select exactly one corner");

endmodule

bind interpolation_weight_3d_unit iw3d_checker u_iw3d_checker (.*);

`default_nettype wire
